### rtl/core/cltok_pkg.sv
// Shared constants, record type and character-class helpers for the source tokenizer.
package cltok_pkg;

  // Position counter width; offsets, lines and columns saturate at all ones
  localparam int POS_W = 24;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Token kinds
  localparam logic [2:0] K_IDENT  = 3'd0;
  localparam logic [2:0] K_NUMBER = 3'd1;
  localparam logic [2:0] K_STRING = 3'd2;
  localparam logic [2:0] K_SYMBOL = 3'd3;
  localparam logic [2:0] K_EOF    = 3'd4;

  // Error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_BLOCK  = 2'd1;
  localparam logic [1:0] ERR_STRING = 2'd2;

  // Characters of interest
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_USCORE = 8'h5F;

  // One token record as queued toward the result channel
  typedef struct packed {
    logic [2:0]       kind;
    logic [POS_W-1:0] span_start;
    logic [POS_W-1:0] span_end;
    logic [POS_W-1:0] line;
    logic [POS_W-1:0] column;
    logic [1:0]       err;
    logic             last;
  } tok_rec_t;

  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
    sat_inc = (v == POS_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    is_space = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    is_word = is_digit(b) || (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
              (b == CH_USCORE);
  endfunction

  function automatic logic may_pair(input logic [7:0] b);
    may_pair = (b == CH_LT) || (b == CH_EQ) || (b == CH_BANG) || (b == CH_MINUS) ||
               (b == CH_COLON);
  endfunction

  function automatic logic pairs_with(input logic [7:0] f, input logic [7:0] s);
    pairs_with = (f == CH_LT && s == CH_EQ) || (f == CH_EQ && s == CH_EQ) ||
                 (f == CH_BANG && s == CH_EQ) || (f == CH_MINUS && s == CH_GT) ||
                 (f == CH_COLON && s == CH_COLON);
  endfunction

  function automatic tok_rec_t mk_rec(input logic [2:0] kind, input logic [POS_W-1:0] s,
                                      input logic [POS_W-1:0] e, input logic [POS_W-1:0] l,
                                      input logic [POS_W-1:0] c, input logic [1:0] err);
    tok_rec_t r;
    r.kind       = kind;
    r.span_start = s;
    r.span_end   = e;
    r.line       = l;
    r.column     = c;
    r.err        = err;
    r.last       = 1'b0;
    mk_rec = r;
  endfunction

endpackage

### rtl/core/cltok_if.sv
// Valid/ready channel interfaces for source bytes in and token records out.
interface cltok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       byte_present;
  logic       end_of_source;

  modport source (output valid, output source_byte, output byte_present,
                  output end_of_source, input ready);
  modport sink   (input valid, input source_byte, input byte_present,
                  input end_of_source, output ready);
endinterface

interface cltok_out_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  token_kind;
  logic [cltok_pkg::POS_W-1:0] span_start;
  logic [cltok_pkg::POS_W-1:0] span_end;
  logic [cltok_pkg::POS_W-1:0] token_line;
  logic [cltok_pkg::POS_W-1:0] token_column;
  logic [1:0]                  error_code;
  logic                        last_of_run;

  modport source (output valid, output token_kind, output span_start, output span_end,
                  output token_line, output token_column, output error_code,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input span_start, input span_end,
                  input token_line, input token_column, input error_code,
                  input last_of_run, output ready);
endinterface

### rtl/core/c_like_source_tokenizer.sv
// Streaming C-like tokenizer: lexer state machine feeding a four-entry token record queue.
//
//   channel | dir | payload                                          | accepted when
//   --------+-----+--------------------------------------------------+--------------------
//   in_ch   | in  | source_byte, byte_present, end_of_source         | valid && ready
//   out_ch  | out | token_kind, span_start/end, line, column, error, | valid && ready
//           |     | last_of_run                                      |
//
// One source byte is taken per cycle while in_ch.ready is high; the lexer step for a byte
// is a single pass of combinational logic, and its zero to three records are written to the
// queue in that cycle. Records leave one per cycle while out_ch.ready is high, so the rate
// is bounded by the result channel. in_ch.ready is high while the queue holds at most one
// record. rst_n (synchronous) returns the lexer to idle at offset 0, line 1, column 1, and
// empties the queue. A stalled out_ch holds its record steady.
module c_like_source_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  cltok_in_if.sink    in_ch,
  cltok_out_if.source out_ch
);
  import cltok_pkg::*;

  // Lexer modes
  localparam logic [3:0] M_IDLE       = 4'd0;
  localparam logic [3:0] M_IDENT      = 4'd1;
  localparam logic [3:0] M_NUMBER     = 4'd2;
  localparam logic [3:0] M_STRING     = 4'd3;
  localparam logic [3:0] M_STR_ESC    = 4'd4;
  localparam logic [3:0] M_SLASH      = 4'd5;
  localparam logic [3:0] M_LINE       = 4'd6;
  localparam logic [3:0] M_BLOCK      = 4'd7;
  localparam logic [3:0] M_BLOCK_STAR = 4'd8;
  localparam logic [3:0] M_SYM        = 4'd9;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Lexer state
  logic [3:0]       mode_r, mode_nxt;
  logic [7:0]       held_r, held_nxt;
  logic [POS_W-1:0] ts_r, ts_nxt;
  logic [POS_W-1:0] tsl_r, tsl_nxt;
  logic [POS_W-1:0] tsc_r, tsc_nxt;
  logic [POS_W-1:0] bp_r, bp_nxt;
  logic [POS_W-1:0] cl_r, cl_nxt;
  logic [POS_W-1:0] cc_r, cc_nxt;

  // Record queue
  tok_rec_t         q_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     cnt_r;

  tok_rec_t         res [3];
  logic [1:0]       n_res;
  logic             start_new;
  logic [7:0]       b;
  logic             in_fire, out_fire;

  assign b        = in_ch.source_byte;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (cnt_r <= (QAW+1)'(1));

  // Lexer step: one byte, then an optional end of source
  always_comb begin
    mode_nxt  = mode_r;
    held_nxt  = held_r;
    ts_nxt    = ts_r;
    tsl_nxt   = tsl_r;
    tsc_nxt   = tsc_r;
    bp_nxt    = bp_r;
    cl_nxt    = cl_r;
    cc_nxt    = cc_r;
    n_res     = 2'd0;
    start_new = 1'b0;
    for (int i = 0; i < 3; i++) res[i] = '0;

    if (in_ch.byte_present) begin
      unique case (mode_r)
        M_IDENT: begin
          if (!is_word(b)) begin
            res[n_res] = mk_rec(K_IDENT, ts_r, bp_r, tsl_r, tsc_r, ERR_NONE);
            n_res = n_res + 2'd1;
            start_new = 1'b1;
          end
        end
        M_NUMBER: begin
          if (!is_word(b) && b != CH_APOS) begin
            res[n_res] = mk_rec(K_NUMBER, ts_r, bp_r, tsl_r, tsc_r, ERR_NONE);
            n_res = n_res + 2'd1;
            start_new = 1'b1;
          end
        end
        M_STRING: begin
          if (b == CH_DQUOTE) begin
            res[n_res] = mk_rec(K_STRING, ts_r, sat_inc(bp_r), tsl_r, tsc_r, ERR_NONE);
            n_res = n_res + 2'd1;
            mode_nxt = M_IDLE;
          end else if (b == CH_BSLASH) begin
            mode_nxt = M_STR_ESC;
          end
        end
        M_STR_ESC: mode_nxt = M_STRING;
        M_SLASH: begin
          if (b == CH_SLASH) begin
            mode_nxt = M_LINE;
          end else if (b == CH_STAR) begin
            mode_nxt = M_BLOCK;
          end else begin
            res[n_res] = mk_rec(K_SYMBOL, ts_r, bp_r, tsl_r, tsc_r, ERR_NONE);
            n_res = n_res + 2'd1;
            start_new = 1'b1;
          end
        end
        M_LINE: begin
          if (b == CH_NL) mode_nxt = M_IDLE;
        end
        M_BLOCK: begin
          if (b == CH_STAR) mode_nxt = M_BLOCK_STAR;
        end
        M_BLOCK_STAR: begin
          if (b == CH_SLASH) mode_nxt = M_IDLE;
          else if (b != CH_STAR) mode_nxt = M_BLOCK;
        end
        M_SYM: begin
          if (pairs_with(held_r, b)) begin
            res[n_res] = mk_rec(K_SYMBOL, ts_r, sat_inc(bp_r), tsl_r, tsc_r, ERR_NONE);
            n_res = n_res + 2'd1;
            mode_nxt = M_IDLE;
          end else begin
            res[n_res] = mk_rec(K_SYMBOL, ts_r, bp_r, tsl_r, tsc_r, ERR_NONE);
            n_res = n_res + 2'd1;
            start_new = 1'b1;
          end
        end
        default: start_new = 1'b1;
      endcase

      // Start of a new token at this byte
      if (start_new) begin
        mode_nxt = M_IDLE;
        if (!is_space(b)) begin
          ts_nxt  = bp_r;
          tsl_nxt = cl_r;
          tsc_nxt = cc_r;
          if (b == CH_SLASH) begin
            mode_nxt = M_SLASH;
          end else if (is_digit(b)) begin
            mode_nxt = M_NUMBER;
          end else if (is_word(b)) begin
            mode_nxt = M_IDENT;
          end else if (b == CH_DQUOTE) begin
            mode_nxt = M_STRING;
          end else if (may_pair(b)) begin
            mode_nxt = M_SYM;
            held_nxt = b;
          end else begin
            res[n_res] = mk_rec(K_SYMBOL, bp_r, sat_inc(bp_r), cl_r, cc_r, ERR_NONE);
            n_res = n_res + 2'd1;
          end
        end
      end

      // Position counters
      if (b == CH_NL) begin
        cl_nxt = sat_inc(cl_r);
        cc_nxt = POS_W'(1);
      end else begin
        cc_nxt = sat_inc(cc_r);
      end
      bp_nxt = sat_inc(bp_r);
    end

    // End of source: flush pending token, then EOF or error record, then reset
    if (in_ch.end_of_source) begin
      unique case (mode_nxt) inside
        M_IDENT: begin
          res[n_res] = mk_rec(K_IDENT, ts_nxt, bp_nxt, tsl_nxt, tsc_nxt, ERR_NONE);
          n_res = n_res + 2'd1;
        end
        M_NUMBER: begin
          res[n_res] = mk_rec(K_NUMBER, ts_nxt, bp_nxt, tsl_nxt, tsc_nxt, ERR_NONE);
          n_res = n_res + 2'd1;
        end
        M_SLASH, M_SYM: begin
          res[n_res] = mk_rec(K_SYMBOL, ts_nxt, bp_nxt, tsl_nxt, tsc_nxt, ERR_NONE);
          n_res = n_res + 2'd1;
        end
        default: ;
      endcase
      if (mode_nxt == M_STRING || mode_nxt == M_STR_ESC) begin
        res[n_res] = mk_rec(K_EOF, ts_nxt, bp_nxt, tsl_nxt, tsc_nxt, ERR_STRING);
      end else if (mode_nxt == M_BLOCK || mode_nxt == M_BLOCK_STAR) begin
        res[n_res] = mk_rec(K_EOF, ts_nxt, bp_nxt, tsl_nxt, tsc_nxt, ERR_BLOCK);
      end else begin
        res[n_res] = mk_rec(K_EOF, bp_nxt, bp_nxt, cl_nxt, cc_nxt, ERR_NONE);
      end
      n_res = n_res + 2'd1;

      mode_nxt = M_IDLE;
      held_nxt = 8'd0;
      ts_nxt   = '0;
      tsl_nxt  = POS_W'(1);
      tsc_nxt  = POS_W'(1);
      bp_nxt   = '0;
      cl_nxt   = POS_W'(1);
      cc_nxt   = POS_W'(1);
    end

    // Mark the final record of this transaction
    if (n_res != 2'd0) res[n_res - 2'd1].last = 1'b1;
  end

  // Lexer state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      held_r <= 8'd0;
      ts_r   <= '0;
      tsl_r  <= POS_W'(1);
      tsc_r  <= POS_W'(1);
      bp_r   <= '0;
      cl_r   <= POS_W'(1);
      cc_r   <= POS_W'(1);
    end else if (in_fire) begin
      mode_r <= mode_nxt;
      held_r <= held_nxt;
      ts_r   <= ts_nxt;
      tsl_r  <= tsl_nxt;
      tsc_r  <= tsc_nxt;
      bp_r   <= bp_nxt;
      cl_r   <= cl_nxt;
      cc_r   <= cc_nxt;
    end
  end

  // Queue storage: up to three records written per transaction
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < n_res) q_r[wr_ptr_r + QAW'(i)] <= res[i];
      end
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_fire) wr_ptr_r <= wr_ptr_r + QAW'(n_res);
      if (out_fire) rd_ptr_r <= rd_ptr_r + QAW'(1);
      cnt_r <= cnt_r + (in_fire ? (QAW+1)'(n_res) : '0) - (out_fire ? (QAW+1)'(1) : '0);
    end
  end

  // Result channel driven from the queue head
  assign out_ch.valid        = (cnt_r != '0);
  assign out_ch.token_kind   = q_r[rd_ptr_r].kind;
  assign out_ch.span_start   = q_r[rd_ptr_r].span_start;
  assign out_ch.span_end     = q_r[rd_ptr_r].span_end;
  assign out_ch.token_line   = q_r[rd_ptr_r].line;
  assign out_ch.token_column = q_r[rd_ptr_r].column;
  assign out_ch.error_code   = q_r[rd_ptr_r].err;
  assign out_ch.last_of_run  = q_r[rd_ptr_r].last;

  // Queue never overfills
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW+1)'(QDEPTH))
    else $error("token queue overflow");

  // End of source always yields a record and returns the lexer to its reset position
  a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.end_of_source) |-> (n_res != 2'd0))
    else $error("end of source produced no record");

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.end_of_source) |=>
      (mode_r == M_IDLE && bp_r == '0 && cl_r == POS_W'(1) && cc_r == POS_W'(1)))
    else $error("lexer state not reset after end of source");

  // Empty item leaves the lexer untouched
  a_empty_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_ch.byte_present && !in_ch.end_of_source) |=>
      ($stable(mode_r) && $stable(bp_r)))
    else $error("empty item changed lexer state");

endmodule

### sim/tb.sv
// Self-checking testbench for the C-like source tokenizer: a directed table, then random texts.
module tb;
  import cltok_pkg::*;

  typedef logic [POS_W-1:0] pos_t;

  // Lexer states of the token predictor
  typedef enum logic [3:0] {
    LX_IDLE, LX_WORD, LX_NUM, LX_STR, LX_STR_ESC, LX_SLASH, LX_LINE_CMT, LX_BLOCK_CMT,
    LX_BLOCK_STAR, LX_PAIR
  } lex_mode_t;

  // One input transaction, with an optional hand-typed token record
  typedef struct {
    logic [7:0] b;
    logic       present;
    logic       eos;
    bit         typed;
    tok_rec_t   want;
  } step_t;

  localparam tok_rec_t NO_TOK = '0;
  localparam int DIR_ROWS      = 26;
  localparam int TOTAL_ITEMS   = 430;
  localparam int CALM_FROM     = 150;
  localparam int CALM_TO       = 230;
  localparam int HOLD_AT       = 320;
  localparam int HOLD_CYCLES   = 60;
  localparam int SETTLE_CYCLES = 16;

  localparam logic [7:0] LONE_SYMS [11] = '{CH_LT, CH_EQ, CH_BANG, CH_MINUS, CH_COLON, CH_GT,
                                           CH_SLASH, CH_STAR, 8'h3B, 8'h28, 8'h2B};

  logic clk;
  logic rst_n;

  cltok_in_if  in_ch();
  cltok_out_if out_ch();

  c_like_source_tokenizer DUT (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  // Directed table: the empty source, every token kind, pairs, escapes, both error endings
  step_t dir_tab [DIR_ROWS] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, '{K_EOF, 24'd0, 24'd0, 24'd1, 24'd1, ERR_NONE, 1'b1}},
    '{8'h5A, 1'b0, 1'b0, 1'b0, NO_TOK},
    '{CH_USCORE, 1'b1, 1'b0, 1'b0, NO_TOK},
    '{8'h39, 1'b1, 1'b0, 1'b0, NO_TOK},
    '{8'hFF, 1'b1, 1'b0, 1'b0, NO_TOK},
    '{8'h30, 1'b1, 1'b0, 1'b0, NO_TOK},
    '{CH_APOS, 1'b1, 1'b0, 1'b0, NO_TOK},
    '{8'h78, 1'b1, 1'b0, 1'b0, NO_TOK},
    '{CH_LT, 1'b1, 1'b0, 1'b0, NO_TOK},
    '{CH_EQ, 1'b1, 1'b0, 1'b0, NO_TOK},
    '{CH_BANG, 1'b1, 1'b0, 1'b0, NO_TOK},
    '{CH_MINUS, 1'b1, 1'b0, 1'b0, NO_TOK},
    '{CH_GT, 1'b1, 1'b0, 1'b0, NO_TOK},
    '{CH_NL, 1'b1, 1'b0, 1'b0, NO_TOK},
    '{CH_DQUOTE, 1'b1, 1'b0, 1'b0, NO_TOK},
    '{CH_BSLASH, 1'b1, 1'b0, 1'b0, NO_TOK},
    '{CH_DQUOTE, 1'b1, 1'b0, 1'b0, NO_TOK},
    '{CH_DQUOTE, 1'b1, 1'b0, 1'b0, NO_TOK},
    '{CH_SLASH, 1'b1, 1'b0, 1'b0, NO_TOK},
    '{CH_STAR, 1'b1, 1'b0, 1'b0, NO_TOK},
    '{CH_SLASH, 1'b1, 1'b0, 1'b0, NO_TOK},
    '{8'h00, 1'b1, 1'b1, 1'b1, '{K_EOF, 24'd16, 24'd20, 24'd2, 24'd5, ERR_BLOCK, 1'b1}},
    '{CH_DQUOTE, 1'b1, 1'b0, 1'b0, NO_TOK},
    '{8'h71, 1'b1, 1'b1, 1'b1, '{K_EOF, 24'd0, 24'd2, 24'd1, 24'd1, ERR_STRING, 1'b1}},
    '{CH_SLASH, 1'b1, 1'b0, 1'b0, NO_TOK},
    '{CH_SLASH, 1'b1, 1'b1, 1'b1, '{K_EOF, 24'd2, 24'd2, 24'd1, 24'd3, ERR_NONE, 1'b1}}
  };

  // Predictor state
  lex_mode_t  lx_mode;
  logic [7:0] lx_held;
  pos_t       tok_s, tok_l, tok_c;
  pos_t       cur_pos, cur_line, cur_col;

  tok_rec_t item_toks[$];
  tok_rec_t pending_tokens[$];
  step_t    src_q[$];

  int items_sent;
  int sources;
  int tokens_checked;
  int errors_seen;
  int mismatches;
  bit calm;
  bit hold_req;
  bit hold_done;

  // Character classes
  function automatic bit blank(logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic bit digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic bit wordch(logic [7:0] c);
    return digit(c) || (c inside {[8'h41:8'h5A], [8'h61:8'h7A], CH_USCORE});
  endfunction

  function automatic bit pair_lead(logic [7:0] c);
    return c inside {CH_LT, CH_EQ, CH_BANG, CH_MINUS, CH_COLON};
  endfunction

  function automatic bit pair_ok(logic [7:0] a, logic [7:0] c);
    return (c == CH_EQ && (a inside {CH_LT, CH_EQ, CH_BANG})) ||
           (a == CH_MINUS && c == CH_GT) || (a == CH_COLON && c == CH_COLON);
  endfunction

  // Saturating position step
  function automatic pos_t bump(pos_t v);
    return (&v) ? v : v + pos_t'(1);
  endfunction

  function automatic void lex_clear();
    lx_mode  = LX_IDLE;
    lx_held  = '0;
    tok_s    = '0;
    tok_l    = pos_t'(1);
    tok_c    = pos_t'(1);
    cur_pos  = '0;
    cur_line = pos_t'(1);
    cur_col  = pos_t'(1);
  endfunction

  function automatic void push_tok(logic [2:0] k, pos_t s, pos_t e, pos_t l, pos_t c,
                                   logic [1:0] err);
    tok_rec_t r;
    r.kind       = k;
    r.span_start = s;
    r.span_end   = e;
    r.line       = l;
    r.column     = c;
    r.err        = err;
    r.last       = 1'b0;
    item_toks.push_back(r);
  endfunction

  function automatic void push_open(logic [2:0] k, pos_t e);
    push_tok(k, tok_s, e, tok_l, tok_c, ERR_NONE);
  endfunction

  // First byte of a new token, or whitespace between tokens
  function automatic void open_token(logic [7:0] c);
    lx_mode = LX_IDLE;
    if (!blank(c)) begin
      tok_s = cur_pos;
      tok_l = cur_line;
      tok_c = cur_col;
      if (c == CH_SLASH) lx_mode = LX_SLASH;
      else if (digit(c)) lx_mode = LX_NUM;
      else if (wordch(c)) lx_mode = LX_WORD;
      else if (c == CH_DQUOTE) lx_mode = LX_STR;
      else if (pair_lead(c)) begin
        lx_mode = LX_PAIR;
        lx_held = c;
      end else push_open(K_SYMBOL, bump(cur_pos));
    end
  endfunction

  function automatic void lex_byte(logic [7:0] c);
    case (lx_mode)
      LX_WORD: begin
        if (!wordch(c)) begin
          push_open(K_IDENT, cur_pos);
          open_token(c);
        end
      end
      LX_NUM: begin
        if (!wordch(c) && c != CH_APOS) begin
          push_open(K_NUMBER, cur_pos);
          open_token(c);
        end
      end
      LX_STR: begin
        if (c == CH_DQUOTE) begin
          push_open(K_STRING, bump(cur_pos));
          lx_mode = LX_IDLE;
        end else if (c == CH_BSLASH) lx_mode = LX_STR_ESC;
      end
      LX_STR_ESC: lx_mode = LX_STR;
      LX_SLASH: begin
        if (c == CH_SLASH) lx_mode = LX_LINE_CMT;
        else if (c == CH_STAR) lx_mode = LX_BLOCK_CMT;
        else begin
          push_open(K_SYMBOL, cur_pos);
          open_token(c);
        end
      end
      LX_LINE_CMT: if (c == CH_NL) lx_mode = LX_IDLE;
      LX_BLOCK_CMT: if (c == CH_STAR) lx_mode = LX_BLOCK_STAR;
      LX_BLOCK_STAR: begin
        if (c == CH_SLASH) lx_mode = LX_IDLE;
        else if (c != CH_STAR) lx_mode = LX_BLOCK_CMT;
      end
      LX_PAIR: begin
        if (pair_ok(lx_held, c)) begin
          push_open(K_SYMBOL, bump(cur_pos));
          lx_mode = LX_IDLE;
        end else begin
          push_open(K_SYMBOL, cur_pos);
          open_token(c);
        end
      end
      default: open_token(c);
    endcase
    // Position bookkeeping; column restarts after a newline
    if (c == CH_NL) begin
      cur_line = bump(cur_line);
      cur_col  = pos_t'(1);
    end else cur_col = bump(cur_col);
    cur_pos = bump(cur_pos);
  endfunction

  // End of text: flush the open token, then EOF or an error record
  function automatic void lex_end();
    logic [1:0] err;
    err = ERR_NONE;
    case (lx_mode) inside
      LX_WORD: push_open(K_IDENT, cur_pos);
      LX_NUM: push_open(K_NUMBER, cur_pos);
      LX_SLASH, LX_PAIR: push_open(K_SYMBOL, cur_pos);
      LX_STR, LX_STR_ESC: err = ERR_STRING;
      LX_BLOCK_CMT, LX_BLOCK_STAR: err = ERR_BLOCK;
      default: ;
    endcase
    if (err != ERR_NONE) push_tok(K_EOF, tok_s, cur_pos, tok_l, tok_c, err);
    else push_tok(K_EOF, cur_pos, cur_pos, cur_line, cur_col, ERR_NONE);
    lex_clear();
  endfunction

  function automatic void predict_item(logic [7:0] c, logic present, logic eos);
    tok_rec_t r;
    item_toks.delete();
    if (present) lex_byte(c);
    if (eos) lex_end();
    if (item_toks.size() != 0) begin
      r = item_toks.pop_back();
      r.last = 1'b1;
      item_toks.push_back(r);
    end
  endfunction

  // Random text helpers
  function automatic logic [7:0] letter_byte();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'(8'h61 + r);
    if (r < 52) return 8'(8'h41 + r - 26);
    return CH_USCORE;
  endfunction

  function automatic logic [7:0] word_byte();
    if ($urandom_range(0, 5) == 0) return 8'(8'h30 + $urandom_range(0, 9));
    return letter_byte();
  endfunction

  // Printable, never a quote or a backslash
  function automatic logic [7:0] text_byte();
    logic [7:0] c;
    c = 8'($urandom_range(8'h20, 8'h7E));
    if (c == CH_DQUOTE || c == CH_BSLASH) c = 8'h78;
    return c;
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_NL;
      3: return 8'h0B;
      4: return 8'h0C;
      default: return CH_CR;
    endcase
  endfunction

  // Appends one byte, now and then after an empty transaction
  function automatic void add_byte(logic [7:0] c);
    if ($urandom_range(0, 24) == 0)
      src_q.push_back(step_t'{8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, NO_TOK});
    src_q.push_back(step_t'{c, 1'b1, 1'b0, 1'b0, NO_TOK});
  endfunction

  // One source text: well-formed fragments, some noise, sometimes an open ending
  function automatic void compose_source();
    int frags;
    int n;
    logic [7:0] c;
    step_t tail_step;
    frags = $urandom_range(0, 8);
    for (int f = 0; f < frags; f++) begin
      n = $urandom_range(0, 6);
      case ($urandom_range(0, 11)) inside
        0, 1: begin
          add_byte(letter_byte());
          repeat (n) add_byte(word_byte());
        end
        2: begin
          add_byte(8'(8'h30 + $urandom_range(0, 9)));
          repeat (n) add_byte(($urandom_range(0, 4) == 0) ? CH_APOS : word_byte());
        end
        3: begin
          add_byte(CH_DQUOTE);
          repeat (n) begin
            if ($urandom_range(0, 3) == 0) begin
              add_byte(CH_BSLASH);
              add_byte(8'($urandom_range(0, 255)));
            end else add_byte(text_byte());
          end
          add_byte(CH_DQUOTE);
        end
        4: begin
          case ($urandom_range(0, 4))
            0: begin add_byte(CH_LT); add_byte(CH_EQ); end
            1: begin add_byte(CH_EQ); add_byte(CH_EQ); end
            2: begin add_byte(CH_BANG); add_byte(CH_EQ); end
            3: begin add_byte(CH_MINUS); add_byte(CH_GT); end
            default: begin add_byte(CH_COLON); add_byte(CH_COLON); end
          endcase
        end
        5: begin
          if ($urandom_range(0, 3) == 0) add_byte(8'(8'h80 + $urandom_range(0, 127)));
          else add_byte(LONE_SYMS[$urandom_range(0, 10)]);
        end
        6: begin
          add_byte(CH_SLASH);
          add_byte(CH_SLASH);
          repeat (n) begin
            c = 8'($urandom_range(0, 255));
            add_byte((c == CH_NL) ? CH_SPACE : c);
          end
          add_byte(CH_NL);
        end
        7: begin
          add_byte(CH_SLASH);
          add_byte(CH_STAR);
          repeat (n) begin
            case ($urandom_range(0, 4))
              0: add_byte(CH_STAR);
              1: add_byte(CH_SLASH);
              2: add_byte(CH_NL);
              default: add_byte(text_byte());
            endcase
          end
          if ($urandom_range(0, 1) == 0) add_byte(CH_STAR);
          add_byte(CH_STAR);
          add_byte(CH_SLASH);
        end
        8, 9: repeat (n + 1) add_byte(blank_byte());
        10: repeat (n + 1) add_byte(8'($urandom_range(0, 255)));
        default: add_byte(CH_NL);
      endcase
      if ($urandom_range(0, 1) == 0) add_byte(blank_byte());
    end
    // Text that stops inside a string or a comment
    n = $urandom_range(0, 5);
    case ($urandom_range(0, 15))
      0: begin add_byte(CH_DQUOTE); repeat (n) add_byte(text_byte()); end
      1: begin add_byte(CH_DQUOTE); add_byte(text_byte()); add_byte(CH_BSLASH); end
      2: begin add_byte(CH_SLASH); add_byte(CH_STAR); repeat (n) add_byte(text_byte()); end
      3: begin add_byte(CH_SLASH); add_byte(CH_STAR); add_byte(CH_STAR); end
      4: begin add_byte(CH_SLASH); add_byte(CH_SLASH); add_byte(text_byte()); end
      default: ;
    endcase
    // End marker: on the last transaction or on an empty one of its own
    if (src_q.size() != 0 && $urandom_range(0, 1) == 0) begin
      tail_step = src_q.pop_back();
      tail_step.eos = 1'b1;
      src_q.push_back(tail_step);
    end else begin
      src_q.push_back(step_t'{8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, NO_TOK});
    end
  endfunction

  // Offers one transaction, waits for the handshake and records what it should produce
  task automatic send(input step_t s);
    if (s.present || s.eos) items_sent++;
    calm = (items_sent >= CALM_FROM) && (items_sent < CALM_TO);
    if (items_sent >= HOLD_AT && !hold_done) begin
      hold_req  = 1'b1;
      hold_done = 1'b1;
    end
    while (!calm && $urandom_range(0, 99) < 17) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.source_byte   <= s.b;
    in_ch.byte_present  <= s.present;
    in_ch.end_of_source <= s.eos;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(s.b, s.present, s.eos);
    if (s.typed) begin
      item_toks.delete();
      item_toks.push_back(s.want);
    end
    foreach (item_toks[i]) pending_tokens.push_back(item_toks[i]);
    if (s.eos) sources++;
    @(negedge clk);
  endtask

  function automatic void field_check(string name, logic [POS_W-1:0] want,
                                      logic [POS_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("token %0d: %s expected %0d, got %0d", tokens_checked, name, want, got);
    end
  endfunction

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
  end

  // Token record checker
  always @(posedge clk) begin
    tok_rec_t got;
    tok_rec_t want_tok;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind       = out_ch.token_kind;
      got.span_start = out_ch.span_start;
      got.span_end   = out_ch.span_end;
      got.line       = out_ch.token_line;
      got.column     = out_ch.token_column;
      got.err        = out_ch.error_code;
      got.last       = out_ch.last_of_run;
      tokens_checked++;
      if (got.err != ERR_NONE) errors_seen++;
      if (pending_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected token: kind %0d span %0d..%0d line %0d col %0d err %0d",
                   got.kind, got.span_start, got.span_end, got.line, got.column, got.err);
      end else begin
        want_tok = pending_tokens.pop_front();
        field_check("kind", POS_W'(want_tok.kind), POS_W'(got.kind));
        field_check("span_start", want_tok.span_start, got.span_start);
        field_check("span_end", want_tok.span_end, got.span_end);
        field_check("line", want_tok.line, got.line);
        field_check("column", want_tok.column, got.column);
        field_check("error_code", POS_W'(want_tok.err), POS_W'(got.err));
        field_check("last_of_run", POS_W'(want_tok.last), POS_W'(got.last));
      end
    end
  end

  // Result side: random stalls, one long hold-off to back the block up
  initial begin
    int held;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          out_ch.ready <= 1'b0;
          held++;
          @(negedge clk);
        end
      end else begin
        out_ch.ready <= calm || ($urandom_range(0, 99) >= 17);
        @(negedge clk);
      end
    end
  end

  // Source side: directed table, random texts, then drain and verdict
  initial begin
    int guard;
    in_ch.valid         = 1'b0;
    in_ch.source_byte   = '0;
    in_ch.byte_present  = 1'b0;
    in_ch.end_of_source = 1'b0;
    lex_clear();
    wait (rst_n === 1'b1);
    @(negedge clk);
    foreach (dir_tab[i]) send(dir_tab[i]);
    while (items_sent < TOTAL_ITEMS) begin
      src_q.delete();
      compose_source();
      foreach (src_q[i]) send(src_q[i]);
    end
    in_ch.valid <= 1'b0;
    guard = 0;
    while (pending_tokens.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_tokens.size() != 0) begin
      $display("%0d expected token records never arrived", pending_tokens.size());
      mismatches += pending_tokens.size();
    end
    $display("Fed %0d transactions over %0d source texts; checked %0d token records (%0d errors).",
             items_sent, sources, tokens_checked, errors_seen);
    $display("Included a %0d-cycle result stall and a stretch with no idling on either side.",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

endmodule
